FILE: hw/rtl/sequential_bayesian_evidence_update_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sequential Bayesian evidence update
// Short forms for concurrent assertions clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_BAYESIAN_EVIDENCE_UPDATE_DEFINES_SVH
`define SEQUENTIAL_BAYESIAN_EVIDENCE_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBEU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBEU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sbeu_pkg.sv
// ----------------------------------------------------------------------------
// Sequential Bayesian evidence update package
// Widths, constants, types and helpers shared by the update datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbeu_pkg;

    // Fixed-point format: FRAC_BITS fraction bits, 1.0 is 2^FRAC_BITS.
    localparam int FRAC_BITS = 16;
    localparam int ONE_W     = FRAC_BITS + 1;
    localparam int PRIOR_W   = FRAC_BITS;
    localparam int LIK_W     = 2 * FRAC_BITS + 1;
    localparam int EV_W      = 3 * FRAC_BITS + 1;

    // Serial multiplier digits.
    localparam int DIGIT_W   = 4;
    localparam int N_DIG     = (ONE_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W     = N_DIG * DIGIT_W;
    localparam int DIG_CNT_W = $clog2(N_DIG);
    localparam int PP_W      = DIGIT_W + ONE_W;
    localparam int PN_W      = DIGIT_W + LIK_W;

    // Divider step counter.
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ONE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AI_REL = CFG_IDX_W'(1);

    localparam logic [ONE_W-1:0]   ONE_Q        = ONE_W'(1) << FRAC_BITS;
    localparam logic [PRIOR_W-1:0] PRIOR_RESET  = PRIOR_W'(1) << (FRAC_BITS - 1);
    localparam logic [ONE_W-1:0]   AI_REL_RESET = ONE_W'((9 * (2 ** FRAC_BITS)) / 10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIK,
        ST_PROD,
        ST_DEN,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a Q1.16 value to 1.0.
    function automatic logic [ONE_W-1:0] sat_one(input logic [ONE_W-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sbeu_div.sv
// ----------------------------------------------------------------------------
// Posterior divider: 0 for a zero divisor, 1.0 when num >= den, else
// restoring division giving floor(num * 2^FRAC_BITS / den), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbeu_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [sbeu_pkg::EV_W-1:0]      num,
    input  wire logic [sbeu_pkg::EV_W-1:0]      den,
    output logic      [sbeu_pkg::ONE_W-1:0]     quot,
    output sbeu_pkg::div_stat_t                 stat
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [sbeu_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [sbeu_pkg::EV_W:0]          rem_reg, rem_next;
    logic [sbeu_pkg::EV_W-1:0]        den_reg, den_next;
    logic [sbeu_pkg::ONE_W-1:0]       quot_reg, quot_next;

    logic [sbeu_pkg::EV_W:0]          shifted;
    logic [sbeu_pkg::EV_W:0]          diff;
    logic                             ge;

    // The remainder stays below the divisor, so its top bit is always clear.
    assign shifted = {rem_reg[sbeu_pkg::EV_W-1:0], 1'b0};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            den_next  = den;
            rem_next  = {1'b0, num};
            quot_next = '0;
            if (den == '0)
            begin
                done_next = 1'b1;
            end
            else if (num >= den)
            begin
                quot_next = sbeu_pkg::ONE_Q;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff : shifted;
            quot_next = {quot_reg[sbeu_pkg::ONE_W-2:0], ge};
            if (cnt_reg == sbeu_pkg::DIV_CNT_W'(sbeu_pkg::FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sequential_bayesian_evidence_update.sv
// ----------------------------------------------------------------------------
// Sequential Bayesian evidence update
// Keeps a running posterior in Q1.16 and updates it with one evidence item
// per transfer, emitting the new posterior for every item.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  cfg      cfg_we               cfg_index, cfg_data (prior, AI reliability)
//  in       in_valid / in_ready  start_req, confidence, reliability, last_in
//  out      out_valid/out_ready  posterior_out, status, last_out
//
//  An item with a computed update runs the likelihood pass, the evidence
//  pass, the denominator sum and the divider before its result reaches
//  out_valid; no new item is taken until then. The two multiply passes are
//  digit-serial and the divider gives one bit a cycle. An evidence item with
//  zero reliability goes straight to the done state. Reset is asynchronous
//  and active low; it clears the posterior and the fault flag and restores
//  the register defaults. A stalled output only holds the finished item
//  in its final state; the output register frees once its transfer completes.
//
`default_nettype none

`include "sequential_bayesian_evidence_update_defines.svh"

module sequential_bayesian_evidence_update (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sbeu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbeu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               start_req,
    input  wire logic [sbeu_pkg::ONE_W-1:0]         confidence,
    input  wire logic [sbeu_pkg::ONE_W-1:0]         reliability,
    input  wire logic                               last_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [sbeu_pkg::ONE_W-1:0]         posterior_out,
    output logic                                    status,
    output logic                                    last_out
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sbeu_pkg::state_t                  state_reg, state_next;

    // Control state and configuration, initialised by reset.
    logic [sbeu_pkg::DIG_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              fault_reg, fault_next;
    logic                              upd_reg, upd_next;
    logic [sbeu_pkg::ONE_W-1:0]        post_reg, post_next;
    logic                              out_valid_reg, out_valid_next;
    logic [sbeu_pkg::PRIOR_W-1:0]      prior_reg, prior_next;
    logic [sbeu_pkg::ONE_W-1:0]        ai_rel_reg, ai_rel_next;

    // Datapath. The digit registers shift left one digit per cycle in their
    // pass so that the most significant digit always sits at the top.
    logic [sbeu_pkg::PAD_W-1:0]        conf_reg, conf_next;
    logic [sbeu_pkg::PAD_W-1:0]        confb_reg, confb_next;
    logic [sbeu_pkg::ONE_W-1:0]        rel_reg, rel_next;
    logic [sbeu_pkg::ONE_W-1:0]        relb_reg, relb_next;
    logic [sbeu_pkg::PAD_W-1:0]        p_reg, p_next;
    logic [sbeu_pkg::PAD_W-1:0]        pb_reg, pb_next;
    logic [sbeu_pkg::LIK_W-1:0]        lpos_reg, lpos_next;
    logic [sbeu_pkg::LIK_W-1:0]        lneg_reg, lneg_next;
    logic [sbeu_pkg::EV_W-1:0]         num_reg, num_next;
    logic [sbeu_pkg::EV_W-1:0]         neg_reg, neg_next;
    logic [sbeu_pkg::EV_W-1:0]         den_reg, den_next;
    logic                              last_reg, last_next;
    logic [sbeu_pkg::ONE_W-1:0]        posterior_out_reg, posterior_out_next;
    logic                              status_reg, status_next;
    logic                              last_out_reg, last_out_next;

    // ------------------------------------------------------------------
    // Input conditioning
    // ------------------------------------------------------------------
    // Values above 1.0 are clamped. A start item restarts from the prior
    // and uses the configured AI reliability in place of its own.
    logic [sbeu_pkg::ONE_W-1:0]        c_sat;
    logic [sbeu_pkg::ONE_W-1:0]        r_sel;
    logic [sbeu_pkg::ONE_W-1:0]        p_sel;
    logic                              in_xfer;

    assign c_sat   = sbeu_pkg::sat_one(confidence);
    assign r_sel   = start_req ? sbeu_pkg::sat_one(ai_rel_reg)
                               : sbeu_pkg::sat_one(reliability);
    assign p_sel   = start_req ? sbeu_pkg::ONE_W'(prior_reg)
                               : sbeu_pkg::sat_one(post_reg);
    assign in_ready = (state_reg == sbeu_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Likelihood pass: one digit of c and of (1 - c) per cycle.
    //   Lpos = r*c + (1-r)*(1-c),  Lneg = r*(1-c) + (1-r)*c
    // ------------------------------------------------------------------
    logic [sbeu_pkg::DIGIT_W-1:0]      c_d, cb_d;
    logic [sbeu_pkg::PP_W-1:0]         pp_rc, pp_rbcb, pp_rcb, pp_rbc;
    logic [sbeu_pkg::LIK_W-1:0]        lpos_sum, lneg_sum;

    assign c_d     = conf_reg[sbeu_pkg::PAD_W-1 -: sbeu_pkg::DIGIT_W];
    assign cb_d    = confb_reg[sbeu_pkg::PAD_W-1 -: sbeu_pkg::DIGIT_W];
    assign pp_rc   = sbeu_pkg::PP_W'(c_d)  * sbeu_pkg::PP_W'(rel_reg);
    assign pp_rbcb = sbeu_pkg::PP_W'(cb_d) * sbeu_pkg::PP_W'(relb_reg);
    assign pp_rcb  = sbeu_pkg::PP_W'(cb_d) * sbeu_pkg::PP_W'(rel_reg);
    assign pp_rbc  = sbeu_pkg::PP_W'(c_d)  * sbeu_pkg::PP_W'(relb_reg);

    // The accumulator only ever holds a prefix of the final product, so the
    // bits lost by the digit shift are always zero.
    assign lpos_sum = {lpos_reg[sbeu_pkg::LIK_W-sbeu_pkg::DIGIT_W-1:0],
                       {sbeu_pkg::DIGIT_W{1'b0}}}
                    + sbeu_pkg::LIK_W'(pp_rc) + sbeu_pkg::LIK_W'(pp_rbcb);
    assign lneg_sum = {lneg_reg[sbeu_pkg::LIK_W-sbeu_pkg::DIGIT_W-1:0],
                       {sbeu_pkg::DIGIT_W{1'b0}}}
                    + sbeu_pkg::LIK_W'(pp_rcb) + sbeu_pkg::LIK_W'(pp_rbc);

    // ------------------------------------------------------------------
    // Evidence pass: num = P*Lpos and the other term (1-P)*Lneg, one digit
    // of P and of (1 - P) per cycle.
    // ------------------------------------------------------------------
    logic [sbeu_pkg::DIGIT_W-1:0]      p_d, pb_d;
    logic [sbeu_pkg::PN_W-1:0]         pn_pos, pn_neg;
    logic [sbeu_pkg::EV_W-1:0]         num_sum, neg_sum;

    assign p_d    = p_reg[sbeu_pkg::PAD_W-1 -: sbeu_pkg::DIGIT_W];
    assign pb_d   = pb_reg[sbeu_pkg::PAD_W-1 -: sbeu_pkg::DIGIT_W];
    assign pn_pos = sbeu_pkg::PN_W'(p_d)  * sbeu_pkg::PN_W'(lpos_reg);
    assign pn_neg = sbeu_pkg::PN_W'(pb_d) * sbeu_pkg::PN_W'(lneg_reg);

    assign num_sum = {num_reg[sbeu_pkg::EV_W-sbeu_pkg::DIGIT_W-1:0],
                      {sbeu_pkg::DIGIT_W{1'b0}}} + sbeu_pkg::EV_W'(pn_pos);
    assign neg_sum = {neg_reg[sbeu_pkg::EV_W-sbeu_pkg::DIGIT_W-1:0],
                      {sbeu_pkg::DIGIT_W{1'b0}}} + sbeu_pkg::EV_W'(pn_neg);

    logic                              dig_last;
    assign dig_last = (cnt_reg == sbeu_pkg::DIG_CNT_W'(sbeu_pkg::N_DIG - 1));

    // ------------------------------------------------------------------
    // Divider: handles the zero-denominator and full-certainty cases and
    // otherwise produces the quotient one bit per cycle.
    // ------------------------------------------------------------------
    logic                              div_start;
    logic [sbeu_pkg::ONE_W-1:0]        div_quot;
    sbeu_pkg::div_stat_t               div_stat;

    assign div_start = (state_reg == sbeu_pkg::ST_DIV_GO);

    sbeu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        fault_next         = fault_reg;
        upd_next           = upd_reg;
        post_next          = post_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        prior_next         = prior_reg;
        ai_rel_next        = ai_rel_reg;
        conf_next          = conf_reg;
        confb_next         = confb_reg;
        rel_next           = rel_reg;
        relb_next          = relb_reg;
        p_next             = p_reg;
        pb_next            = pb_reg;
        lpos_next          = lpos_reg;
        lneg_next          = lneg_reg;
        num_next           = num_reg;
        neg_next           = neg_reg;
        den_next           = den_reg;
        last_next          = last_reg;
        posterior_out_next = posterior_out_reg;
        status_next        = status_reg;
        last_out_next      = last_out_reg;

        // Configuration must only be written while idle; it is not enforced.
        if (cfg_we)
        begin
            case (cfg_index)
                sbeu_pkg::CFG_PRIOR:  prior_next  = cfg_data[sbeu_pkg::PRIOR_W-1:0];
                sbeu_pkg::CFG_AI_REL: ai_rel_next = cfg_data[sbeu_pkg::ONE_W-1:0];
                default:              prior_next  = prior_reg;
            endcase
        end

        case (state_reg)
            sbeu_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    conf_next  = sbeu_pkg::PAD_W'(c_sat);
                    confb_next = sbeu_pkg::PAD_W'(sbeu_pkg::ONE_Q - c_sat);
                    rel_next   = r_sel;
                    relb_next  = sbeu_pkg::ONE_Q - r_sel;
                    p_next     = sbeu_pkg::PAD_W'(p_sel);
                    pb_next    = sbeu_pkg::PAD_W'(sbeu_pkg::ONE_Q - p_sel);
                    lpos_next  = '0;
                    lneg_next  = '0;
                    num_next   = '0;
                    neg_next   = '0;
                    cnt_next   = '0;
                    last_next  = last_in;
                    if (!start_req && (r_sel == '0))
                    begin
                        // Invalid evidence: the posterior is held and the
                        // chain is flagged until the next start item.
                        fault_next = 1'b1;
                        upd_next   = 1'b0;
                        state_next = sbeu_pkg::ST_DONE;
                    end
                    else
                    begin
                        if (start_req)
                        begin
                            fault_next = 1'b0;
                        end
                        upd_next   = 1'b1;
                        state_next = sbeu_pkg::ST_LIK;
                    end
                end
            end

            sbeu_pkg::ST_LIK:
            begin
                lpos_next  = lpos_sum;
                lneg_next  = lneg_sum;
                conf_next  = conf_reg << sbeu_pkg::DIGIT_W;
                confb_next = confb_reg << sbeu_pkg::DIGIT_W;
                if (dig_last)
                begin
                    cnt_next   = '0;
                    state_next = sbeu_pkg::ST_PROD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            sbeu_pkg::ST_PROD:
            begin
                num_next = num_sum;
                neg_next = neg_sum;
                p_next   = p_reg << sbeu_pkg::DIGIT_W;
                pb_next  = pb_reg << sbeu_pkg::DIGIT_W;
                if (dig_last)
                begin
                    cnt_next   = '0;
                    state_next = sbeu_pkg::ST_DEN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            sbeu_pkg::ST_DEN:
            begin
                // Lpos + Lneg is exactly 1.0 squared, so num + neg fits.
                den_next   = num_reg + neg_reg;
                state_next = sbeu_pkg::ST_DIV_GO;
            end

            sbeu_pkg::ST_DIV_GO:
            begin
                state_next = sbeu_pkg::ST_DIV;
            end

            sbeu_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = sbeu_pkg::ST_DONE;
                end
            end

            sbeu_pkg::ST_DONE:
            begin
                // Wait here only while the previous result is still unsent.
                if (!out_valid_reg || out_ready)
                begin
                    if (upd_reg)
                    begin
                        post_next          = div_quot;
                        posterior_out_next = div_quot;
                    end
                    else
                    begin
                        posterior_out_next = post_reg;
                    end
                    status_next    = fault_reg;
                    last_out_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = sbeu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sbeu_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbeu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            fault_reg     <= 1'b0;
            upd_reg       <= 1'b0;
            post_reg      <= '0;
            out_valid_reg <= 1'b0;
            prior_reg     <= sbeu_pkg::PRIOR_RESET;
            ai_rel_reg    <= sbeu_pkg::AI_REL_RESET;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            fault_reg     <= fault_next;
            upd_reg       <= upd_next;
            post_reg      <= post_next;
            out_valid_reg <= out_valid_next;
            prior_reg     <= prior_next;
            ai_rel_reg    <= ai_rel_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        conf_reg          <= conf_next;
        confb_reg         <= confb_next;
        rel_reg           <= rel_next;
        relb_reg          <= relb_next;
        p_reg             <= p_next;
        pb_reg            <= pb_next;
        lpos_reg          <= lpos_next;
        lneg_reg          <= lneg_next;
        num_reg           <= num_next;
        neg_reg           <= neg_next;
        den_reg           <= den_next;
        last_reg          <= last_next;
        posterior_out_reg <= posterior_out_next;
        status_reg        <= status_next;
        last_out_reg      <= last_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign posterior_out = posterior_out_reg;
    assign status        = status_reg;
    assign last_out      = last_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SBEU_ASSERT_IMP(a_div_done_while_waiting, div_stat.done,
        state_reg == sbeu_pkg::ST_DIV, "divider finished outside the wait state")
    `SBEU_ASSERT_IMP(a_no_input_while_dividing, div_stat.busy,
        !in_ready, "input taken while the divider is busy")
    `SBEU_ASSERT_IMP(a_posterior_bounded, out_valid,
        posterior_out <= sbeu_pkg::ONE_Q, "posterior above 1.0")
    `SBEU_ASSERT_NXT(a_start_clears_fault, in_valid && in_ready && start_req,
        !fault_reg, "start item did not clear the chain fault")

endmodule

`default_nettype wire

FILE: tb/sbeu_posterior_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Posterior checker for the sequential Bayesian evidence update
// Watches the register port and both channels, works out the posterior,
// fault flag and last marker for every accepted item, and compares each
// output transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module sbeu_posterior_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sbeu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sbeu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic                            start_req,
    input  wire logic [sbeu_pkg::ONE_W-1:0]      confidence,
    input  wire logic [sbeu_pkg::ONE_W-1:0]      reliability,
    input  wire logic                            last_in,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [sbeu_pkg::ONE_W-1:0]      posterior_out,
    input  wire logic                            status,
    input  wire logic                            last_out,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    typedef struct packed {
        logic [sbeu_pkg::ONE_W-1:0] posterior;
        logic                       status;
        logic                       last_flag;
    } posterior_result_t;

    posterior_result_t  awaited_posteriors[$];

    logic [sbeu_pkg::PRIOR_W-1:0] prior_reg;
    logic [sbeu_pkg::ONE_W-1:0]   ai_rel_reg;
    logic [sbeu_pkg::ONE_W-1:0]   posterior_q;
    logic                         fault_q;

    function automatic logic [sbeu_pkg::ONE_W-1:0] clamp_unit(
        input logic [sbeu_pkg::ONE_W-1:0] v);
        return (v > sbeu_pkg::ONE_Q) ? sbeu_pkg::ONE_Q : v;
    endfunction

    // Exact Bayes step on 64-bit products; the quotient is taken from an
    // 80-bit dividend so that no fraction bit is lost.
    function automatic logic [sbeu_pkg::ONE_W-1:0] next_posterior(
        input logic [sbeu_pkg::ONE_W-1:0] p,
        input logic [sbeu_pkg::ONE_W-1:0] c,
        input logic [sbeu_pkg::ONE_W-1:0] r);
        logic [63:0] one;
        logic [63:0] like_pos;
        logic [63:0] like_neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [79:0] quotient;
        one      = 64'(sbeu_pkg::ONE_Q);
        like_pos = 64'(r) * 64'(c) + (one - 64'(r)) * (one - 64'(c));
        like_neg = 64'(r) * (one - 64'(c)) + (one - 64'(r)) * 64'(c);
        num      = 64'(p) * like_pos;
        den      = num + (one - 64'(p)) * like_neg;
        if (den == 64'd0)
            return '0;
        if (num >= den)
            return sbeu_pkg::ONE_Q;
        quotient = (80'(num) << sbeu_pkg::FRAC_BITS) / 80'(den);
        return sbeu_pkg::ONE_W'(quotient);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        posterior_result_t          want;
        logic [sbeu_pkg::ONE_W-1:0] conf_sat;
        logic [sbeu_pkg::ONE_W-1:0] rel_sat;
        if (!rst_n)
        begin
            prior_reg   = sbeu_pkg::PRIOR_RESET;
            ai_rel_reg  = sbeu_pkg::AI_REL_RESET;
            posterior_q = '0;
            fault_q     = 1'b0;
            awaited_posteriors.delete();
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sbeu_pkg::CFG_PRIOR:  prior_reg  = cfg_data[sbeu_pkg::PRIOR_W-1:0];
                    sbeu_pkg::CFG_AI_REL: ai_rel_reg = cfg_data;
                    default:              ;
                endcase
            end

            // Results leave in a later cycle than their item is taken, so the
            // output side is handled before this cycle's input.
            if (out_valid && out_ready)
            begin
                checked++;
                if (awaited_posteriors.size() == 0)
                begin
                    $error("unexpected result: posterior_out=%0d status=%0d last_out=%0d",
                           posterior_out, status, last_out);
                    fail_count++;
                end
                else
                begin
                    want = awaited_posteriors.pop_front();
                    if (posterior_out !== want.posterior)
                    begin
                        $error("posterior_out: expected %0d, got %0d",
                               want.posterior, posterior_out);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (last_out !== want.last_flag)
                    begin
                        $error("last_out: expected %0d, got %0d", want.last_flag, last_out);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                conf_sat = clamp_unit(confidence);
                rel_sat  = clamp_unit(reliability);
                if (start_req)
                begin
                    posterior_q = next_posterior(sbeu_pkg::ONE_W'(prior_reg), conf_sat,
                                                 clamp_unit(ai_rel_reg));
                    fault_q     = 1'b0;
                end
                else if (rel_sat == '0)
                    fault_q = 1'b1;
                else
                    posterior_q = next_posterior(clamp_unit(posterior_q), conf_sat, rel_sat);
                awaited_posteriors.push_back('{posterior: posterior_q, status: fault_q,
                                               last_flag: last_in});
            end

            pending = awaited_posteriors.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sequential Bayesian evidence update
// Drives evidence chains and register settings into the block with random
// gaps on the input and random back-pressure on the output; a separate
// checker predicts every posterior and reports the mismatches it finds.
// ----------------------------------------------------------------------------

module testbench;

    // Even with the longest input gaps and output stalls, a slow run of some
    // 1900 items stays well under this limit.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int SETTLE_CYCLES = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sbeu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sbeu_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic                            start_req;
    logic [sbeu_pkg::ONE_W-1:0]      confidence;
    logic [sbeu_pkg::ONE_W-1:0]      reliability;
    logic                            last_in;
    logic                            out_valid;
    logic                            out_ready;
    logic [sbeu_pkg::ONE_W-1:0]      posterior_out;
    logic                            status;
    logic                            last_out;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int chains_sent = 0;
    int cfg_writes  = 0;

    // While calm is set neither side idles, so the block runs flat out.
    bit calm = 1'b0;

    sequential_bayesian_evidence_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .confidence    (confidence),
        .reliability   (reliability),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .posterior_out (posterior_out),
        .status        (status),
        .last_out      (last_out)
    );

    sbeu_posterior_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .confidence    (confidence),
        .reliability   (reliability),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .posterior_out (posterior_out),
        .status        (status),
        .last_out      (last_out),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped by the cycle limit with %0d results outstanding.", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly short idle stretches, with the odd long one.
    function automatic int idle_span();
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 31);
        if (pick < 14)
            return 0;
        if (pick < 30)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output back-pressure. Ready and stall stretches alternate at random;
    // an occasional long stall makes the block hold a finished item.
    initial
    begin
        int  stretch;
        bit  take;
        out_ready = 1'b0;
        stretch   = 0;
        take      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                if (calm)
                begin
                    take    = 1'b1;
                    stretch = 1;
                end
                else
                begin
                    take    = 1'($urandom_range(0, 1));
                    stretch = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 60)
                                                           : $urandom_range(1, 4);
                end
            end
            out_ready <= take;
            stretch--;
        end
    end

    // Confidence values: mostly within [0, 1.0], with the extremes, values
    // above 1.0 that must saturate and the odd fully random word.
    function automatic logic [sbeu_pkg::ONE_W-1:0] pick_confidence();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return sbeu_pkg::ONE_Q;
            2:       return sbeu_pkg::ONE_W'($urandom_range(int'(sbeu_pkg::ONE_Q) + 1,
                                                            17'h1FFFF));
            3:       return sbeu_pkg::ONE_W'($urandom);
            default: return sbeu_pkg::ONE_W'($urandom_range(0, int'(sbeu_pkg::ONE_Q)));
        endcase
    endfunction

    // Reliability values: zero now and then to raise the chain fault, plus
    // the same extremes as the confidence.
    function automatic logic [sbeu_pkg::ONE_W-1:0] pick_reliability();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return sbeu_pkg::ONE_Q;
            2:       return sbeu_pkg::ONE_W'($urandom_range(int'(sbeu_pkg::ONE_Q) + 1,
                                                            17'h1FFFF));
            3:       return sbeu_pkg::ONE_W'($urandom);
            4:       return sbeu_pkg::ONE_W'($urandom_range(1, 255));
            default: return sbeu_pkg::ONE_W'($urandom_range(1, int'(sbeu_pkg::ONE_Q)));
        endcase
    endfunction

    // Presents one item after a random gap and returns at the edge where
    // its transfer completes, leaving valid high for the next call.
    task automatic send_item(input bit start, input logic [sbeu_pkg::ONE_W-1:0] conf,
                             input logic [sbeu_pkg::ONE_W-1:0] rel, input bit last);
        int gap;
        gap = idle_span();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        start_req   <= start;
        confidence  <= conf;
        reliability <= rel;
        last_in     <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // A start item followed by a run of evidence. A tidy chain marks only its
    // final item as last; an untidy one scatters the last marker at random.
    task automatic send_chain(input bit tidy);
        int links;
        links = $urandom_range(0, 10);
        chains_sent++;
        send_item(1'b1, pick_confidence(), sbeu_pkg::ONE_W'($urandom),
                  tidy ? (links == 0) : 1'($urandom));
        for (int k = 1; k <= links; k++)
            send_item(1'b0, pick_confidence(), pick_reliability(),
                      tidy ? (k == links) : 1'($urandom));
    endtask

    // Drops valid and holds the input back until every posterior is out, so
    // that the block is idle for a register write.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [sbeu_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sbeu_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_registers(input logic [sbeu_pkg::CFG_DATA_W-1:0] prior,
                                 input logic [sbeu_pkg::CFG_DATA_W-1:0] ai_rel);
        drain_results();
        write_register(sbeu_pkg::CFG_PRIOR, prior);
        write_register(sbeu_pkg::CFG_AI_REL, ai_rel);
    endtask

    initial
    begin
        int target;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = sbeu_pkg::CFG_PRIOR;
        cfg_data    = '0;
        in_valid    = 1'b0;
        start_req   = 1'b0;
        confidence  = '0;
        reliability = '0;
        last_in     = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset register values first. Evidence before
        // any start works from the reset posterior of zero, and certain
        // evidence against a zero posterior gives a zero denominator.
        send_item(1'b0, sbeu_pkg::ONE_W'(40000), sbeu_pkg::ONE_W'(50000), 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_Q, sbeu_pkg::ONE_Q, 1'b0);
        send_item(1'b1, sbeu_pkg::ONE_Q, '0, 1'b0);
        // Certain evidence drives the posterior to 1.0; certain contrary
        // evidence then zeroes the denominator from the other side.
        send_item(1'b0, sbeu_pkg::ONE_Q, sbeu_pkg::ONE_Q, 1'b0);
        send_item(1'b0, '0, sbeu_pkg::ONE_Q, 1'b0);
        // Zero reliability raises the fault, which survives further evidence
        // (here saturated from above 1.0) and clears on the next start.
        send_item(1'b0, sbeu_pkg::ONE_W'(30000), '0, 1'b0);
        send_item(1'b0, 17'h1FFFF, 17'h1FFFF, 1'b0);
        send_item(1'b1, '0, 17'h1FFFF, 1'b1);
        send_item(1'b1, 17'h1FFFF, sbeu_pkg::ONE_W'(1), 1'b0);
        send_item(1'b0, '0, sbeu_pkg::ONE_W'(1), 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_W'(65535), sbeu_pkg::ONE_W'(65535), 1'b1);
        send_item(1'b1, sbeu_pkg::ONE_W'(32768), sbeu_pkg::ONE_W'(12345), 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_Q, sbeu_pkg::ONE_W'(65535), 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_W'(1), 17'h1FFFF, 1'b1);

        // An over-wide prior keeps only its fraction bits; an AI reliability
        // above 1.0 saturates.
        set_registers(17'h1FFFF, 17'h1FFFF);
        send_item(1'b1, sbeu_pkg::ONE_W'(50000), '0, 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_W'(20000), '0, 1'b1);

        // A zero prior and a zero AI reliability.
        set_registers('0, '0);
        send_item(1'b1, sbeu_pkg::ONE_W'(40000), '0, 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_Q, sbeu_pkg::ONE_Q, 1'b0);
        send_item(1'b1, '0, sbeu_pkg::ONE_Q, 1'b1);

        // The smallest legal settings, then the largest.
        set_registers(17'd1, 17'd1);
        send_item(1'b1, sbeu_pkg::ONE_Q, sbeu_pkg::ONE_Q, 1'b0);
        send_item(1'b0, sbeu_pkg::ONE_Q, sbeu_pkg::ONE_Q, 1'b1);
        set_registers(17'd65535, sbeu_pkg::ONE_Q);
        send_item(1'b1, '0, '0, 1'b0);
        send_item(1'b0, '0, sbeu_pkg::ONE_W'(1), 1'b1);

        // Random part: each phase drains, applies a new setting and then
        // streams mostly well-formed chains with some untidy chains and loose
        // items mixed in. One phase runs with no idling at all.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            calm = 1'b0;
            case (phase)
                1:       set_registers(17'd1, sbeu_pkg::ONE_Q);
                2:       set_registers(17'd65535, 17'd1);
                3:       set_registers(17'h1FFFF, 17'h1FFFF);
                4:       set_registers('0, sbeu_pkg::ONE_Q);
                default: set_registers(sbeu_pkg::CFG_DATA_W'($urandom_range(1, 65535)),
                                       sbeu_pkg::CFG_DATA_W'($urandom_range(1,
                                           int'(sbeu_pkg::ONE_Q))));
            endcase
            calm   = (phase == 5);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_chain(1'b1);
                else if ($urandom_range(0, 1) == 1)
                    send_chain(1'b0);
                else
                    send_item(1'($urandom), pick_confidence(), pick_reliability(),
                              1'($urandom));
            end
        end

        calm = 1'b0;
        drain_results();
        // Give a stray result time to show itself before the verdict.
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d items in %0d chains over %0d register writes; %0d results checked.",
                 items_sent, chains_sent, cfg_writes, checked);
        $display("Settings ranged over zero, minimum, maximum and over-wide register values.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
